// ===== src/acl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types, sizes and the calibration point position table for the
// ADC calibration table builder.
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int LUT_ENTRIES = 4096;
  localparam int CAL_POINTS  = 255;
  localparam int ADC_WIDTH   = 12;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int CODE_W = 8;
  localparam int SMP_W  = 12;
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 20;
  localparam int SUM_W  = 20;
  localparam int SPP_W  = 8;
  localparam int FRAC_W = 8;

  // derived sizes
  localparam int POS_W     = $clog2(LUT_ENTRIES);
  localparam int K_W       = $clog2(CAL_POINTS + 1);
  localparam int AW        = $clog2(CAL_POINTS);
  localparam int SPAN_W    = $clog2((LUT_ENTRIES - 1) / CAL_POINTS + 2) + 1;
  localparam int PROD_W    = SUM_W + SPAN_W;
  localparam int NUM_W     = PROD_W + 1 + FRAC_W;
  localparam int DEN_W     = SPP_W + SPAN_W;
  localparam int EST_SHIFT = $clog2((LUT_ENTRIES - 1) / CAL_POINTS + 1) - 1;

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [SMP_W-1:0] ADC_MASK = SMP_W'((64'd1 << ADC_WIDTH) - 64'd1);
  localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(128);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CODE_W-1:0] dac_code;
    logic [SMP_W-1:0]  adc_sample;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] lut_value;
    logic [IDX_W-1:0] echo_index;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

  typedef logic [(2**K_W)-1:0][POS_W-1:0] pos_tbl_t;

  // table position of each calibration point, round(k*(entries-1)/points)
  function automatic pos_tbl_t build_pos();
    pos_tbl_t t;
    t = '0;
    for (int k = 0; k <= CAL_POINTS; k++) begin
      t[k] = POS_W'((2 * k * (LUT_ENTRIES - 1) + CAL_POINTS) / (2 * CAL_POINTS));
    end
    return t;
  endfunction

  localparam pos_tbl_t POS_TBL = build_pos();

endpackage
`default_nettype wire

// ===== src/adc_calibration_lut_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_calibration_lut_builder
// Per-code sum store for a DAC sweep and interpolated readout of the
// corrected table as unsigned Q12.8.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   in_item_t  (command, code, sample, index)
//  out      output     out_valid_o/out_ready_i out_item_t (lut_value, echo_index)
//  cfg      input      cfg_we_i                samples_per_point
//
//  clear is done on its transfer; an accumulate fetches its sum on transfer, then
//  adds and writes it back in ST_ACC. a read runs the point search, two fetches,
//  a multiply, the divider loop and the output load; a saturating quotient skips
//  the divider loop.
//  reset clears the valid bit of every sum at once, so no clearing pass runs.
//  one item is worked on at a time; a finished result waits in the output
//  register while the next item is taken, and a later read waits for it.
// ----------------------------------------------------------------------------
module adc_calibration_lut_builder
  import acl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [SPP_W-1:0] cfg_wdata_i
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ACC  = 8'b0000_0010,
    ST_SRCH = 8'b0000_0100,
    ST_RD0  = 8'b0000_1000,
    ST_RD1  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e st_q, st_d;

  logic [SUM_W-1:0]      mem_q [CAL_POINTS];
  logic [CAL_POINTS-1:0] vld_q, vld_d;
  logic [SUM_W-1:0]      rd_data_q;
  logic                  rd_ok_q, rd_ok_d;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [SUM_W-1:0]      mem_wdata;

  logic [SPP_W-1:0]  spp_q;
  logic [SPP_W-1:0]  n_w;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic [K_W-1:0]    k_q, k_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  echo_q, echo_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [SMP_W-1:0]  smp_q, smp_d;
  logic [SPAN_W-1:0] span_q, span_d;
  logic [SPAN_W-1:0] d_q, d_d;
  logic [SUM_W-1:0]  s0_q, s0_d;
  logic [PROD_W-1:0] prod0_q, prod0_d;
  logic [PROD_W-1:0] prod1_q, prod1_d;
  logic [DEN_W-1:0]  den_q, den_d;

  logic [SUM_W-1:0]  rd_sum;
  logic [SUM_W:0]    acc_ext;
  logic [K_W-1:0]    k_inc;
  logic [POS_W-1:0]  pos_k, pos_k1;
  logic              step_up, step_dn;
  logic [POS_W-1:0]  idx_c;
  logic [POS_W-1:0]  est;
  logic [PROD_W:0]   lin_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  acl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign n_w     = (spp_q == '0) ? SPP_W'(1) : spp_q;
  assign rd_sum  = rd_ok_q ? rd_data_q : '0;
  assign acc_ext = {1'b0, rd_sum} + (SUM_W + 1)'(smp_q);
  assign k_inc   = k_q + 1'b1;
  assign pos_k   = POS_TBL[k_q];
  assign pos_k1  = POS_TBL[k_inc];
  assign step_up = (32'(k_q) < CAL_POINTS) && (pos_k1 <= idx_q);
  assign step_dn = (k_q != '0) && (pos_k > idx_q);
  assign idx_c   = (32'(in_data_i.read_index) > LUT_ENTRIES - 1) ?
                   POS_W'(LUT_ENTRIES - 1) : POS_W'(in_data_i.read_index);
  assign est     = idx_c >> EST_SHIFT;
  assign lin_sum = (PROD_W + 1)'(prod0_q) + (PROD_W + 1)'(prod1_q);

  assign div_req.start = (st_q == ST_MUL);
  assign div_req.num   = NUM_W'({lin_sum, {FRAC_W{1'b0}}});
  assign div_req.den   = den_q;

  assign mem_wdata = acc_ext[SUM_W] ? SUM_MAX : acc_ext[SUM_W-1:0];
  assign rd_ok_d   = rd_en && vld_q[rd_addr];

  always_comb begin
    st_d        = st_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    k_d         = k_q;
    idx_d       = idx_q;
    echo_d      = echo_q;
    addr_d      = addr_q;
    smp_d       = smp_q;
    span_d      = span_q;
    d_d         = d_q;
    s0_d        = s0_q;
    prod0_d     = prod0_q;
    prod1_d     = prod1_q;
    den_d       = den_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(in_data_i.command))
            CMD_CLEAR: vld_d = '0;
            CMD_ACCUM: begin
              if (in_data_i.dac_code != '0 && 32'(in_data_i.dac_code) <= CAL_POINTS) begin
                rd_en   = 1'b1;
                rd_addr = AW'(in_data_i.dac_code - 1'b1);
                addr_d  = AW'(in_data_i.dac_code - 1'b1);
                smp_d   = in_data_i.adc_sample & ADC_MASK;
                st_d    = ST_ACC;
              end
            end
            CMD_READ: begin
              idx_d  = idx_c;
              echo_d = in_data_i.read_index;
              k_d    = (32'(est) > CAL_POINTS) ? K_W'(CAL_POINTS) : K_W'(est);
              st_d   = ST_SRCH;
            end
            default: ;
          endcase
        end
      end
      ST_ACC: begin
        // saturating add, written back to the entry just fetched
        mem_we        = 1'b1;
        vld_d[addr_q] = 1'b1;
        st_d          = ST_IDLE;
      end
      ST_SRCH: begin
        if (step_up) begin
          k_d = k_inc;
        end else if (step_dn) begin
          k_d = k_q - 1'b1;
        end else begin
          // last point has no right neighbour: plain average
          if (32'(k_q) == CAL_POINTS) begin
            span_d = SPAN_W'(1);
            d_d    = '0;
          end else begin
            span_d = SPAN_W'(pos_k1 - pos_k);
            d_d    = SPAN_W'(idx_q - pos_k);
          end
          // point 0 is not stored and reads as zero
          rd_en   = (k_q != '0);
          rd_addr = AW'(k_q - 1'b1);
          st_d    = ST_RD0;
        end
      end
      ST_RD0: begin
        s0_d    = rd_sum;
        rd_en   = (32'(k_q) != CAL_POINTS);
        rd_addr = AW'(k_q);
        st_d    = ST_RD1;
      end
      ST_RD1: begin
        prod0_d = PROD_W'(s0_q) * PROD_W'(span_q - d_q);
        prod1_d = PROD_W'(rd_sum) * PROD_W'(d_q);
        den_d   = DEN_W'(n_w) * DEN_W'(span_q);
        st_d    = ST_MUL;
      end
      ST_MUL: st_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_data_d.lut_value  = div_rsp.quot;
          out_data_d.echo_index = echo_q;
          st_d                  = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      vld_q       <= '0;
      rd_ok_q     <= 1'b0;
      spp_q       <= SPP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      vld_q       <= vld_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        spp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    k_q        <= k_d;
    idx_q      <= idx_d;
    echo_q     <= echo_d;
    addr_q     <= addr_d;
    smp_q      <= smp_d;
    span_q     <= span_d;
    d_q        <= d_d;
    s0_q       <= s0_d;
    prod0_q    <= prod0_d;
    prod1_q    <= prod1_d;
    den_q      <= den_d;
  end

  // sum store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_acc_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ACC) |-> $past(in_valid_i && in_ready_o))
    else $error("write-back without an accepted accumulate");

  a_search_brackets_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD0) |->
      (pos_k <= idx_q) && ((32'(k_q) == CAL_POINTS) || (pos_k1 > idx_q)))
    else $error("point search ended outside the index bracket");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (st_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_out_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_DONE))
    else $error("result register loaded outside the done phase");

endmodule
`default_nettype wire

// ===== src/acl_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_div
// Bit-serial restoring divider, one quotient bit per cycle, with the
// quotient saturated to all ones when it would not fit.
// ----------------------------------------------------------------------------
module acl_div
  import acl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int W     = (NUM_W > DEN_W + VAL_W) ? NUM_W : DEN_W + VAL_W;
  localparam int CNT_W = $clog2(VAL_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dsh_q, dsh_d;
  logic [VAL_W-1:0] quot_q, quot_d;

  logic [W-1:0] lim;
  logic         sat;
  logic         ge;

  assign lim = W'(req_i.den) << VAL_W;
  assign sat = W'(req_i.num) >= lim;
  assign ge  = rem_q >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (req_i.start) begin
      if (sat) begin
        quot_d = '1;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        rem_d  = W'(req_i.num);
        dsh_d  = W'(req_i.den) << (VAL_W - 1);
        cnt_d  = CNT_W'(VAL_W - 1);
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[VAL_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

// ===== sim/adc_lut_result_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_lut_result_check
// Watches the item, result and register ports of the table builder. It keeps
// its own per-code sums and sample count, works out the interpolated Q12.8
// value for each accepted read, and compares every result transfer field by
// field with the oldest outstanding read.
// ----------------------------------------------------------------------------
module adc_lut_result_check
  import acl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  input  logic             cfg_we_i,
  input  logic [SPP_W-1:0] cfg_wdata_i,
  output int unsigned      fail_count_o,
  output int unsigned      reads_pending_o,
  output int unsigned      reads_checked_o
);

  localparam longint unsigned LUT_VAL_MAX = (64'd1 << VAL_W) - 64'd1;

  logic [SUM_W-1:0] point_sum_q [1:CAL_POINTS];
  logic [SPP_W-1:0] spp_q;
  out_item_t        pending_reads_q [$];
  int unsigned      fail_cnt;
  int unsigned      checked_cnt;

  in_item_t         taken;
  out_item_t        want;
  logic [SUM_W:0]   acc;

  // table position of calibration point k
  function automatic longint unsigned cal_pos(longint unsigned k);
    return (2 * k * (LUT_ENTRIES - 1) + CAL_POINTS) / (2 * CAL_POINTS);
  endfunction

  function automatic longint unsigned sum_at(longint unsigned k);
    if (k == 0) begin
      return 0;
    end
    return point_sum_q[k];
  endfunction

  function automatic logic [VAL_W-1:0] interp_value(logic [IDX_W-1:0] index);
    longint unsigned idx, k, n, num, den, span, d, v;
    idx = index;
    if (idx > LUT_ENTRIES - 1) begin
      idx = LUT_ENTRIES - 1;
    end
    n = (spp_q == '0) ? 1 : spp_q;
    k = idx * CAL_POINTS / (LUT_ENTRIES - 1);
    if (k > CAL_POINTS) begin
      k = CAL_POINTS;
    end
    while (k < CAL_POINTS && cal_pos(k + 1) <= idx) k++;
    while (k > 0 && cal_pos(k) > idx) k--;
    if (k == CAL_POINTS) begin
      num = sum_at(k) * 256;
      den = n;
    end else begin
      span = cal_pos(k + 1) - cal_pos(k);
      d    = idx - cal_pos(k);
      num  = (sum_at(k) * (span - d) + sum_at(k + 1) * d) * 256;
      den  = n * span;
    end
    v = num / den;
    if (v > LUT_VAL_MAX) begin
      v = LUT_VAL_MAX;
    end
    return v[VAL_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= CAL_POINTS; k++) point_sum_q[k] = '0;
      spp_q = SPP_RESET;
      pending_reads_q.delete();
      fail_cnt    = 0;
      checked_cnt = 0;
      fail_count_o    <= 0;
      reads_pending_o <= 0;
      reads_checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        spp_q = cfg_wdata_i;
      end

      if (in_valid_i && in_ready_i) begin
        taken = in_data_i;
        case (taken.command)
          CMD_CLEAR: begin
            for (int k = 1; k <= CAL_POINTS; k++) point_sum_q[k] = '0;
          end
          CMD_ACCUM: begin
            // code 0 has no slot and is dropped
            if (taken.dac_code >= 1 && taken.dac_code <= CAL_POINTS) begin
              acc = point_sum_q[taken.dac_code] + (taken.adc_sample & ADC_MASK);
              if (acc > SUM_MAX) begin
                acc = SUM_MAX;
              end
              point_sum_q[taken.dac_code] = acc[SUM_W-1:0];
            end
          end
          CMD_READ: begin
            want.lut_value  = interp_value(taken.read_index);
            want.echo_index = taken.read_index;
            pending_reads_q.push_back(want);
          end
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (pending_reads_q.size() == 0) begin
          $display("%0t: result transfer with no read outstanding: lut_value %0d echo_index %0d",
                   $time, out_data_i.lut_value, out_data_i.echo_index);
          fail_cnt++;
        end else begin
          want = pending_reads_q.pop_front();
          checked_cnt++;
          if (out_data_i.lut_value !== want.lut_value) begin
            $display("%0t: lut_value mismatch at index %0d: expected %0d, got %0d",
                     $time, want.echo_index, want.lut_value, out_data_i.lut_value);
            fail_cnt++;
          end
          if (out_data_i.echo_index !== want.echo_index) begin
            $display("%0t: echo_index mismatch: expected %0d, got %0d",
                     $time, want.echo_index, out_data_i.echo_index);
            fail_cnt++;
          end
        end
      end

      fail_count_o    <= fail_cnt;
      reads_pending_o <= pending_reads_q.size();
      reads_checked_o <= checked_cnt;
    end
  end

endmodule

// ===== sim/adc_calibration_lut_builder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_calibration_lut_builder_test
// Drives clears, accumulates and table reads into the calibration table
// builder under bursty input and a stalling result side, across several
// sample-count settings, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module adc_calibration_lut_builder_test;
  import acl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int unsigned      QUIET_LIMIT = 2000;
  localparam int unsigned      DRAIN_WAIT  = 40;
  localparam int unsigned      SWEEP_ITEMS = 210;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  in_item_t         in_data_i   = '0;
  logic             out_ready_i = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [SPP_W-1:0] cfg_wdata_i = '0;
  logic             in_ready_o;
  logic             out_valid_o;
  out_item_t        out_data_o;

  int unsigned fail_count;
  int unsigned reads_pending;
  int unsigned reads_checked;

  int unsigned burst_left  = 0;
  int unsigned ready_run   = 0;
  int unsigned ready_mode  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_clear = 0, n_accum = 0, n_read = 0, n_unused = 0, n_settings = 0;

  logic [SPP_W-1:0] spp_plan [6];

  adc_calibration_lut_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  adc_lut_result_check u_lut_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .reads_pending_o (reads_pending),
    .reads_checked_o (reads_checked)
  );

  always #5 clk_i = ~clk_i;

  // result side: runs of always ready, mostly ready, hard stall or toggling
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_run  = (ready_mode == 2) ? $urandom_range(1, 16) : $urandom_range(4, 48);
    end
    ready_run--;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= 1'b0;
      default: out_ready_i <= ~out_ready_i;
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d reads outstanding",
               $time, quiet_cycles, reads_pending);
      $display("adc_calibration_lut_builder_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t mk_item(logic [CMD_W-1:0] cmd, int code, int smp, int idx);
    in_item_t it;
    it.command    = cmd;
    it.dac_code   = CODE_W'(code);
    it.adc_sample = SMP_W'(smp);
    it.read_index = IDX_W'(idx);
    return it;
  endfunction

  // one item through the input channel; bursts with random gaps between
  task automatic push_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    case (it.command)
      CMD_CLEAR: n_clear++;
      CMD_ACCUM: n_accum++;
      CMD_READ:  n_read++;
      default:   n_unused++;
    endcase
  endtask

  // drop valid, wait out every outstanding read and any accumulate in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (reads_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_spp(input logic [SPP_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_sweep(input int unsigned n_items);
    in_item_t    it;
    int unsigned roll;
    int          level;
    for (int unsigned i = 0; i < n_items; i++) begin
      roll          = $urandom_range(0, 99);
      it.dac_code   = CODE_W'($urandom_range(1, CAL_POINTS));
      it.adc_sample = SMP_W'($urandom);
      it.read_index = IDX_W'($urandom);
      if (roll < 3) begin
        it.command = CMD_CLEAR;
      end else if (roll < 6) begin
        it.command = CMD_UNUSED;
      end else if (roll < 10) begin
        it.command  = CMD_ACCUM;
        it.dac_code = '0;
      end else if (roll < 58) begin
        it.command = CMD_ACCUM;
        // half the samples follow a plausible ramp with a little noise
        if ($urandom_range(0, 1) == 0) begin
          level = int'(it.dac_code) * (LUT_ENTRIES - 1) / CAL_POINTS
                  + int'($urandom_range(0, 64)) - 32;
          if (level < 0) level = 0;
          if (level > LUT_ENTRIES - 1) level = LUT_ENTRIES - 1;
          it.adc_sample = SMP_W'(level);
        end
      end else begin
        it.command = CMD_READ;
        if (roll > 93) begin
          it.read_index = (roll[0]) ? IDX_W'(LUT_ENTRIES - 1) : '0;
        end
      end
      push_item(it);
    end
  endtask

  initial begin
    spp_plan[0] = SPP_W'(1);
    spp_plan[1] = SPP_W'(255);
    spp_plan[2] = SPP_W'(0);
    spp_plan[3] = SPP_RESET;
    spp_plan[4] = SPP_W'($urandom_range(2, 254));
    spp_plan[5] = SPP_W'($urandom_range(2, 254));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, then a few points around both ends at the reset count
    push_item(mk_item(CMD_READ, 0, 0, 0));
    push_item(mk_item(CMD_READ, 0, 0, LUT_ENTRIES - 1));
    push_item(mk_item(CMD_ACCUM, 1, ADC_MASK, 0));
    push_item(mk_item(CMD_ACCUM, CAL_POINTS, ADC_MASK, 0));
    push_item(mk_item(CMD_ACCUM, 128, 0, 0));
    push_item(mk_item(CMD_ACCUM, 0, ADC_MASK, 0));
    push_item(mk_item(CMD_UNUSED, CAL_POINTS, ADC_MASK, LUT_ENTRIES - 1));
    push_item(mk_item(CMD_ACCUM, 2, 2048, 0));
    push_item(mk_item(CMD_ACCUM, CAL_POINTS - 1, 1, 0));
    push_item(mk_item(CMD_ACCUM, 1, ADC_MASK, 0));
    push_item(mk_item(CMD_READ, 0, 0, 1));
    push_item(mk_item(CMD_READ, 0, 0, 15));
    push_item(mk_item(CMD_READ, 0, 0, 16));
    push_item(mk_item(CMD_READ, 0, 0, 17));
    push_item(mk_item(CMD_READ, 0, 0, 32));
    push_item(mk_item(CMD_READ, 0, 0, 2048));
    push_item(mk_item(CMD_READ, 0, 0, 4079));
    push_item(mk_item(CMD_READ, 0, 0, 4080));
    push_item(mk_item(CMD_READ, 0, 0, LUT_ENTRIES - 2));
    push_item(mk_item(CMD_READ, 0, 0, LUT_ENTRIES - 1));
    push_item(mk_item(CMD_READ, 0, 0, 0));
    push_item(mk_item(CMD_CLEAR, 0, 0, 0));
    push_item(mk_item(CMD_READ, 0, 0, LUT_ENTRIES - 1));
    push_item(mk_item(CMD_READ, 0, 0, 16));

    for (int p = 0; p < 6; p++) begin
      write_spp(spp_plan[p]);
      run_sweep(SWEEP_ITEMS);
    end

    // full-scale samples into the top point and point 1, with reads near the top end
    write_spp(SPP_W'(1));
    push_item(mk_item(CMD_CLEAR, 0, 0, 0));
    for (int i = 0; i < 280; i++) begin
      push_item(mk_item(CMD_ACCUM, (i % 4 == 3) ? 1 : CAL_POINTS, ADC_MASK, $urandom));
      if (i % 20 == 19) begin
        push_item(mk_item(CMD_READ, 0, 0,
                          (i % 40 == 19) ? LUT_ENTRIES - 1
                                         : LUT_ENTRIES - 1 - $urandom_range(1, 20)));
      end
    end

    write_spp(SPP_W'($urandom_range(1, 255)));
    run_sweep(SWEEP_ITEMS / 2);
    settle();

    $display("input transfers: %0d clears, %0d accumulates, %0d reads, %0d unused commands",
             n_clear, n_accum, n_read, n_unused);
    $display("%0d reads checked over %0d sample-count writes, zero and full scale included",
             reads_checked, n_settings);
    if (fail_count == 0) begin
      $display("adc_calibration_lut_builder_test: PASS");
    end else begin
      $display("adc_calibration_lut_builder_test: FAIL");
    end
    $finish;
  end

endmodule
